[rtl/core/bcc_pkg.sv]
// ============================================================================
// Box-circle contact package
// Shared widths, request and result types, and pipeline stage record.
// ============================================================================
package bcc_pkg;

    // Coordinate width of the signed centre fields.
    localparam int COORD_BITS = 24;
    // Width of half extents and radius (positive magnitudes).
    localparam int MAG_W      = COORD_BITS - 1;
    // Bounds carry one extra bit, differences two.
    localparam int BND_W      = COORD_BITS + 1;
    localparam int DIFF_W     = COORD_BITS + 2;
    localparam int DEPTH_W    = COORD_BITS + 1;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int ROOT_W     = COORD_BITS;
    localparam int SQ_W       = 2 * ROOT_W;
    localparam int NORM_W     = 16;
    localparam int QUO_W      = 15;
    localparam int QUO_FRAC   = QUO_W - 1;
    localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(16384);

    typedef enum logic [1:0] {
        FACE_NX = 2'd0,
        FACE_PX = 2'd1,
        FACE_NY = 2'd2,
        FACE_PY = 2'd3
    } face_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] box_x;
        logic signed [COORD_BITS-1:0] box_y;
        logic        [MAG_W-1:0]      half_width;
        logic        [MAG_W-1:0]      half_height;
        logic signed [COORD_BITS-1:0] circle_x;
        logic signed [COORD_BITS-1:0] circle_y;
        logic        [MAG_W-1:0]      radius;
    } in_t;

    typedef struct packed {
        logic                     hit;
        logic [DEPTH_W-1:0]       depth;
        logic signed [NORM_W-1:0] normal_x;
        logic signed [NORM_W-1:0] normal_y;
    } out_t;

    typedef struct packed {
        in_t                       req;
        logic signed [BND_W-1:0]   xlo;
        logic signed [BND_W-1:0]   xhi;
        logic signed [BND_W-1:0]   ylo;
        logic signed [BND_W-1:0]   yhi;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  d0;
        logic signed [DIFF_W-1:0]  d1;
        logic signed [DIFF_W-1:0]  d2;
        logic signed [DIFF_W-1:0]  d3;
        logic                      near;
        logic                      sx;
        logic                      sy;
        logic [MAG_W-1:0]          adx;
        logic [MAG_W-1:0]          ady;
        face_t                     best;
        logic signed [DIFF_W-1:0]  dbest;
        logic [PROD_W-1:0]         sqx;
        logic [PROD_W-1:0]         sqy;
        logic [PROD_W-1:0]         rr;
        logic [DEPTH_W-1:0]        dep;
        logic                      zero;
        logic [SQ_W-1:0]           sqv;
        logic [ROOT_W+1:0]         srem;
        logic [ROOT_W-1:0]         root;
        logic [MAG_W-1:0]          len;
        logic [MAG_W:0]            remx;
        logic [MAG_W:0]            remy;
        logic [QUO_W-1:0]          qx;
        logic [QUO_W-1:0]          qy;
        out_t                      res;
    } pipe_t;

endpackage

[rtl/core/box_circle_contact_top.sv]
// ============================================================================
// Box-circle contact pipeline
// Clamp, square, root and normalize stages for box versus circle contact.
// ============================================================================
// Throughput: one request per cycle unless the output stalls; the 24-stage
// square root and the 15-stage normal divider are fully pipelined, one
// result bit per stage. Each stage stalls only when it holds a request
// and the next stage cannot take it.
// Reset clears all stage valid bits; stage payload is not reset.
module box_circle_contact_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bcc_pkg::in_t   in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output bcc_pkg::out_t  out_data
);

    // Stage map. Every stage holds one pipe record plus its valid bit.
    localparam int S_IN    = 0;                      // request capture
    localparam int S_BND   = 1;                      // box bounds
    localparam int S_DIF   = 2;                      // clamp offsets, face distances
    localparam int S_ABS   = 3;                      // magnitudes, near test, face pick
    localparam int S_MUL   = 4;                      // squares of offsets and radius
    localparam int S_SUM   = 5;                      // squared distance, hit
    localparam int S_SQ0   = 6;                      // first square root stage
    localparam int S_LEN   = S_SQ0 + bcc_pkg::ROOT_W; // depth, divider setup
    localparam int S_DV0   = S_LEN + 1;              // first divider stage
    localparam int S_OUT   = S_DV0 + bcc_pkg::QUO_W; // normal signs, result
    localparam int N_STAGE = S_OUT + 1;

    bcc_pkg::pipe_t      pipe_reg [N_STAGE];
    logic [N_STAGE-1:0]  vld_reg;
    logic [N_STAGE:0]    rdy;

    // A stage can take a new request when it is empty or its occupant moves on.
    assign rdy[N_STAGE] = out_ready;
    assign in_ready     = rdy[0];
    assign out_valid    = vld_reg[N_STAGE-1];
    assign out_data     = pipe_reg[N_STAGE-1].res;

    for (genvar k = 0; k < N_STAGE; k++) begin : g_st
        bcc_pkg::pipe_t  pipe_next;
        logic            vin;

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        if (k == S_IN) begin : g_in
            assign vin = in_valid;
            always_comb
            begin
                pipe_next     = '0;
                pipe_next.req = in_data;
            end
        end else begin : g_work
            assign vin = vld_reg[k-1];

            if (k == S_BND) begin : g_bnd
                always_comb
                begin
                    pipe_next     = pipe_reg[k-1];
                    pipe_next.xlo = bcc_pkg::BND_W'(pipe_reg[k-1].req.box_x)
                                  - $signed({2'b00, pipe_reg[k-1].req.half_width});
                    pipe_next.xhi = bcc_pkg::BND_W'(pipe_reg[k-1].req.box_x)
                                  + $signed({2'b00, pipe_reg[k-1].req.half_width});
                    pipe_next.ylo = bcc_pkg::BND_W'(pipe_reg[k-1].req.box_y)
                                  - $signed({2'b00, pipe_reg[k-1].req.half_height});
                    pipe_next.yhi = bcc_pkg::BND_W'(pipe_reg[k-1].req.box_y)
                                  + $signed({2'b00, pipe_reg[k-1].req.half_height});
                end
            end else if (k == S_DIF) begin : g_dif
                logic signed [bcc_pkg::BND_W-1:0] cxe;
                logic signed [bcc_pkg::BND_W-1:0] cye;
                logic signed [bcc_pkg::BND_W-1:0] clx;
                logic signed [bcc_pkg::BND_W-1:0] cly;
                always_comb
                begin
                    pipe_next = pipe_reg[k-1];
                    cxe = bcc_pkg::BND_W'(pipe_reg[k-1].req.circle_x);
                    cye = bcc_pkg::BND_W'(pipe_reg[k-1].req.circle_y);
                    if (cxe < pipe_reg[k-1].xlo)
                        clx = pipe_reg[k-1].xlo;
                    else if (cxe > pipe_reg[k-1].xhi)
                        clx = pipe_reg[k-1].xhi;
                    else
                        clx = cxe;
                    if (cye < pipe_reg[k-1].ylo)
                        cly = pipe_reg[k-1].ylo;
                    else if (cye > pipe_reg[k-1].yhi)
                        cly = pipe_reg[k-1].yhi;
                    else
                        cly = cye;
                    pipe_next.dx = bcc_pkg::DIFF_W'(cxe) - bcc_pkg::DIFF_W'(clx);
                    pipe_next.dy = bcc_pkg::DIFF_W'(cye) - bcc_pkg::DIFF_W'(cly);
                    pipe_next.d0 = bcc_pkg::DIFF_W'(cxe)
                                 - bcc_pkg::DIFF_W'(pipe_reg[k-1].xlo);
                    pipe_next.d1 = bcc_pkg::DIFF_W'(pipe_reg[k-1].xhi)
                                 - bcc_pkg::DIFF_W'(cxe);
                    pipe_next.d2 = bcc_pkg::DIFF_W'(cye)
                                 - bcc_pkg::DIFF_W'(pipe_reg[k-1].ylo);
                    pipe_next.d3 = bcc_pkg::DIFF_W'(pipe_reg[k-1].yhi)
                                 - bcc_pkg::DIFF_W'(cye);
                end
            end else if (k == S_ABS) begin : g_abs
                logic [bcc_pkg::DIFF_W-1:0]        ax;
                logic [bcc_pkg::DIFF_W-1:0]        ay;
                logic [bcc_pkg::DIFF_W-1:0]        rw;
                bcc_pkg::face_t                    fa;
                bcc_pkg::face_t                    fb;
                logic signed [bcc_pkg::DIFF_W-1:0] da;
                logic signed [bcc_pkg::DIFF_W-1:0] db;
                always_comb
                begin
                    pipe_next = pipe_reg[k-1];
                    ax = pipe_reg[k-1].dx[bcc_pkg::DIFF_W-1] ? -pipe_reg[k-1].dx
                                                             : pipe_reg[k-1].dx;
                    ay = pipe_reg[k-1].dy[bcc_pkg::DIFF_W-1] ? -pipe_reg[k-1].dy
                                                             : pipe_reg[k-1].dy;
                    rw = bcc_pkg::DIFF_W'(pipe_reg[k-1].req.radius);
                    pipe_next.near = (ax <= rw) && (ay <= rw);
                    pipe_next.sx   = pipe_reg[k-1].dx[bcc_pkg::DIFF_W-1];
                    pipe_next.sy   = pipe_reg[k-1].dy[bcc_pkg::DIFF_W-1];
                    pipe_next.adx  = ax[bcc_pkg::MAG_W-1:0];
                    pipe_next.ady  = ay[bcc_pkg::MAG_W-1:0];
                    // Ties keep the earlier face in the order -x, +x, -y, +y.
                    if (pipe_reg[k-1].d1 < pipe_reg[k-1].d0)
                    begin
                        fa = bcc_pkg::FACE_PX;
                        da = pipe_reg[k-1].d1;
                    end else begin
                        fa = bcc_pkg::FACE_NX;
                        da = pipe_reg[k-1].d0;
                    end
                    if (pipe_reg[k-1].d3 < pipe_reg[k-1].d2)
                    begin
                        fb = bcc_pkg::FACE_PY;
                        db = pipe_reg[k-1].d3;
                    end else begin
                        fb = bcc_pkg::FACE_NY;
                        db = pipe_reg[k-1].d2;
                    end
                    if (db < da)
                    begin
                        pipe_next.best  = fb;
                        pipe_next.dbest = db;
                    end else begin
                        pipe_next.best  = fa;
                        pipe_next.dbest = da;
                    end
                end
            end else if (k == S_MUL) begin : g_mul
                logic [bcc_pkg::DIFF_W-1:0] dsum;
                always_comb
                begin
                    pipe_next     = pipe_reg[k-1];
                    pipe_next.sqx = pipe_reg[k-1].adx * pipe_reg[k-1].adx;
                    pipe_next.sqy = pipe_reg[k-1].ady * pipe_reg[k-1].ady;
                    pipe_next.rr  = pipe_reg[k-1].req.radius * pipe_reg[k-1].req.radius;
                    dsum = pipe_reg[k-1].dbest
                         + bcc_pkg::DIFF_W'(pipe_reg[k-1].req.radius);
                    pipe_next.dep = dsum[bcc_pkg::DEPTH_W-1:0];
                end
            end else if (k == S_SUM) begin : g_sum
                logic [bcc_pkg::PROD_W:0] sq;
                always_comb
                begin
                    pipe_next      = pipe_reg[k-1];
                    sq             = {1'b0, pipe_reg[k-1].sqx} + {1'b0, pipe_reg[k-1].sqy};
                    pipe_next.res  = '0;
                    pipe_next.res.hit = pipe_reg[k-1].near
                                     && (sq <= {1'b0, pipe_reg[k-1].rr});
                    pipe_next.zero = (sq == '0);
                    pipe_next.sqv  = bcc_pkg::SQ_W'(sq);
                    pipe_next.srem = '0;
                    pipe_next.root = '0;
                end
            end else if (k < S_LEN) begin : g_sqrt
                // One root bit per stage: bring down two radicand bits and
                // try subtracting 4*root + 1.
                logic [bcc_pkg::ROOT_W+1:0] rsh;
                logic [bcc_pkg::ROOT_W+1:0] trial;
                always_comb
                begin
                    pipe_next = pipe_reg[k-1];
                    rsh   = {pipe_reg[k-1].srem[bcc_pkg::ROOT_W-1:0],
                             pipe_reg[k-1].sqv[bcc_pkg::SQ_W-1 -: 2]};
                    trial = {pipe_reg[k-1].root, 2'b01};
                    pipe_next.sqv = {pipe_reg[k-1].sqv[bcc_pkg::SQ_W-3:0], 2'b00};
                    if (rsh >= trial)
                    begin
                        pipe_next.srem = rsh - trial;
                        pipe_next.root = {pipe_reg[k-1].root[bcc_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        pipe_next.srem = rsh;
                        pipe_next.root = {pipe_reg[k-1].root[bcc_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
            end else if (k == S_LEN) begin : g_len
                logic [bcc_pkg::MAG_W-1:0] ln;
                always_comb
                begin
                    pipe_next      = pipe_reg[k-1];
                    ln             = pipe_reg[k-1].root[bcc_pkg::MAG_W-1:0];
                    pipe_next.len  = ln;
                    pipe_next.remx = {1'b0, pipe_reg[k-1].adx};
                    pipe_next.remy = {1'b0, pipe_reg[k-1].ady};
                    pipe_next.qx   = '0;
                    pipe_next.qy   = '0;
                    if (!pipe_reg[k-1].res.hit)
                        pipe_next.res.depth = '0;
                    else if (pipe_reg[k-1].zero)
                        pipe_next.res.depth = pipe_reg[k-1].dep;
                    else
                        pipe_next.res.depth = bcc_pkg::DEPTH_W'(
                            pipe_reg[k-1].req.radius - ln);
                end
            end else if (k < S_OUT) begin : g_div
                // Restoring division of offset * 2^14 by the root. The offset
                // never exceeds the root, so the first step needs no shift.
                logic [bcc_pkg::MAG_W:0] shx;
                logic [bcc_pkg::MAG_W:0] shy;
                logic [bcc_pkg::MAG_W:0] lw;
                logic                    gx;
                logic                    gy;
                always_comb
                begin
                    pipe_next = pipe_reg[k-1];
                    lw = {1'b0, pipe_reg[k-1].len};
                    if (k == S_DV0)
                    begin
                        shx = pipe_reg[k-1].remx;
                        shy = pipe_reg[k-1].remy;
                    end else begin
                        shx = {pipe_reg[k-1].remx[bcc_pkg::MAG_W-1:0], 1'b0};
                        shy = {pipe_reg[k-1].remy[bcc_pkg::MAG_W-1:0], 1'b0};
                    end
                    gx = (shx >= lw);
                    gy = (shy >= lw);
                    pipe_next.remx = gx ? shx - lw : shx;
                    pipe_next.remy = gy ? shy - lw : shy;
                    pipe_next.qx   = {pipe_reg[k-1].qx[bcc_pkg::QUO_W-2:0], gx};
                    pipe_next.qy   = {pipe_reg[k-1].qy[bcc_pkg::QUO_W-2:0], gy};
                end
            end else begin : g_out
                logic [bcc_pkg::NORM_W-1:0] ux;
                logic [bcc_pkg::NORM_W-1:0] uy;
                always_comb
                begin
                    pipe_next = pipe_reg[k-1];
                    ux = bcc_pkg::NORM_W'(pipe_reg[k-1].qx);
                    uy = bcc_pkg::NORM_W'(pipe_reg[k-1].qy);
                    pipe_next.res.normal_x = '0;
                    pipe_next.res.normal_y = '0;
                    if (pipe_reg[k-1].res.hit)
                    begin
                        if (pipe_reg[k-1].zero)
                        begin
                            unique case (pipe_reg[k-1].best)
                                bcc_pkg::FACE_NX: pipe_next.res.normal_x = -bcc_pkg::NORM_ONE;
                                bcc_pkg::FACE_PX: pipe_next.res.normal_x = bcc_pkg::NORM_ONE;
                                bcc_pkg::FACE_NY: pipe_next.res.normal_y = -bcc_pkg::NORM_ONE;
                                bcc_pkg::FACE_PY: pipe_next.res.normal_y = bcc_pkg::NORM_ONE;
                                default:          pipe_next.res.normal_x = '0;
                            endcase
                        end else begin
                            pipe_next.res.normal_x = pipe_reg[k-1].sx ? -ux : ux;
                            pipe_next.res.normal_y = pipe_reg[k-1].sy ? -uy : uy;
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && vin)
                pipe_reg[k] <= pipe_next;
        end
    end

    // A miss carries no depth and no normal.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |->
            out_data.depth == '0 && out_data.normal_x == '0 && out_data.normal_y == '0)
        else $error("miss result with nonzero depth or normal");

    // With nothing waiting at the output every stage can advance.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output stage");

    // Normal components never exceed unit length.
    a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            $signed(out_data.normal_x) <= $signed(bcc_pkg::NORM_ONE)
            && $signed(out_data.normal_x) >= -$signed(bcc_pkg::NORM_ONE)
            && $signed(out_data.normal_y) <= $signed(bcc_pkg::NORM_ONE)
            && $signed(out_data.normal_y) >= -$signed(bcc_pkg::NORM_ONE))
        else $error("normal component out of range");

endmodule
